/* hdl/thsc_pkg.sv */
// Shared types, constants and the CRC-8 byte step for the scratchpad checker.
// Used by every module of the thermometer_scratchpad_checker block; no dependencies.
package thsc_pkg;

	// Frame geometry and CRC polynomial (reflected form).
	localparam int unsigned FRAME_LEN = 9;
	localparam int unsigned CRC_LEN   = 8;
	localparam logic [7:0]  CRC_POLY  = 8'h8C;

	// Byte position of the CRC byte, the last byte of a frame.
	localparam logic [3:0] POS_CRC = 4'(FRAME_LEN - 1);
	localparam logic [3:0] POS_LO  = 4'd0;
	localparam logic [3:0] POS_HI  = 4'd1;

	// Valid result range in signed sixteenths of a degree (-55 to 125 degrees).
	localparam logic signed [16:0] TEMP_MIN = -17'sd880;
	localparam logic signed [16:0] TEMP_MAX = 17'sd2000;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_ALL_ZERO  = 2'd1,
		ST_CRC_ERR   = 2'd2,
		ST_RANGE_ERR = 2'd3
	} status_t;

	// Result of one byte as seen by the output stage.
	typedef struct packed {
		logic               done;
		status_t            status;
		logic signed [11:0] temperature;
	} result_t;

	// One full byte of the reflected CRC-8, eight shallow bit steps.
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
		logic [7:0] crc;
		logic [7:0] d;
		logic       mix;
		crc = crc_in;
		d   = data;
		for (int i = 0; i < 8; i++) begin
			mix = crc[0] ^ d[0];
			crc = crc >> 1;
			if (mix) begin
				crc = crc ^ CRC_POLY;
			end
			d = d >> 1;
		end
		return crc;
	endfunction

endpackage

/* hdl/thsc_frame.sv */
// Frame tracker: byte position, running CRC, all-zero flag and temperature bytes.
// Produces the frame verdict on the CRC byte. Depends on thsc_pkg.
module thsc_frame (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  logic [7:0]                data,
	input  logic                      start,
	input  logic signed [12:0]        offset,
	output thsc_pkg::result_t         result,
	output logic [3:0]                position
);
	import thsc_pkg::*;

	logic [3:0]         pos_q;
	logic [7:0]         crc_q;
	logic               zero_q;
	logic [7:0]         lo_q;
	logic [7:0]         hi_q;

	logic               clr;
	logic [3:0]         pos_eff;
	logic [7:0]         crc_eff;
	logic               zero_eff;
	logic [7:0]         lo_eff;
	logic [7:0]         hi_eff;
	logic               zero_new;
	logic               last;
	logic signed [16:0] sum;

	// A frame start, or position zero, begins a fresh frame with this byte.
	assign clr      = start || (pos_q == '0);
	assign pos_eff  = clr ? 4'd0 : pos_q;
	assign crc_eff  = clr ? 8'd0 : crc_q;
	assign zero_eff = clr ? 1'b1 : zero_q;
	assign lo_eff   = clr ? 8'd0 : lo_q;
	assign hi_eff   = clr ? 8'd0 : hi_q;
	assign zero_new = zero_eff && (data == 8'd0);
	assign last     = (pos_eff == POS_CRC);

	// Raw reading plus trim at full width, so the range check sees no wrap.
	assign sum = 17'(signed'({hi_eff, lo_eff})) + 17'(offset);

	// Verdict in priority order: all zero, CRC mismatch, out of range.
	always_comb begin
		result.done        = last;
		result.status      = ST_OK;
		result.temperature = '0;
		if (zero_new) begin
			result.status = ST_ALL_ZERO;
		end else if (crc_eff != data) begin
			result.status = ST_CRC_ERR;
		end else if ((sum < TEMP_MIN) || (sum > TEMP_MAX)) begin
			result.status = ST_RANGE_ERR;
		end else begin
			result.temperature = sum[11:0];
		end
	end

	// Frame state advances once per byte transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			crc_q  <= '0;
			zero_q <= 1'b1;
			lo_q   <= '0;
			hi_q   <= '0;
		end else if (step) begin
			if (last) begin
				pos_q  <= '0;
				crc_q  <= '0;
				zero_q <= 1'b1;
				lo_q   <= '0;
				hi_q   <= '0;
			end else begin
				pos_q  <= pos_eff + 4'd1;
				crc_q  <= (pos_eff < 4'(CRC_LEN)) ? crc8_byte(crc_eff, data) : crc_eff;
				zero_q <= zero_new;
				lo_q   <= (pos_eff == POS_LO) ? data : lo_eff;
				hi_q   <= (pos_eff == POS_HI) ? data : hi_eff;
			end
		end
	end

	assign position = pos_q;

endmodule

/* hdl/thsc_out_stage.sv */
// Output register for frame results with valid/stall handshake.
// Depends on thsc_pkg.
module thsc_out_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  thsc_pkg::result_t    result,
	input  logic                 stall,
	output logic                 valid,
	output logic                 free,
	output logic [1:0]           status,
	output logic signed [11:0]   temperature
);
	import thsc_pkg::*;

	logic               valid_q;
	status_t            status_q;
	logic signed [11:0] temp_q;

	// The register can take a new result when empty or being drained this cycle.
	assign free = !valid_q || !stall;

	// Valid flag: set on a load, cleared when the result is transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	// Payload needs no reset.
	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= result.status;
			temp_q   <= result.temperature;
		end
	end

	assign valid       = valid_q;
	assign status      = status_q;
	assign temperature = temp_q;

endmodule

/* hdl/thermometer_scratchpad_checker.sv */
// Scratchpad frame checker: CRC-8, all-zero and range check of nine-byte frames.
// Result path: a frame's CRC byte is held in the input register, then checked and loaded into the output register.
// Throughput: one byte per cycle; stall from the output holds back only the CRC byte.
// Reset: asynchronous, active low; clears frame state, offset to 0, no result pending.
// Top level; depends on thsc_pkg, thsc_frame and thsc_out_stage.
module thermometer_scratchpad_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          scratch_byte,
	input  logic                frame_start,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          status,
	output logic signed [11:0]  temperature,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic signed [12:0]  cfg_data
);
	import thsc_pkg::*;

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               start_s1;
	logic signed [12:0] offset_q;
	result_t            result;
	logic [3:0]         position;
	logic               out_free;
	logic               advance;
	logic               in_xfer;

	// Input stage moves on unless its byte ends a frame and the output is full.
	assign advance  = valid_s1 && (!result.done || out_free);
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1  <= scratch_byte;
			start_s1 <= frame_start;
		end
	end

	// Calibration offset register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			offset_q <= cfg_data;
		end
	end

	thsc_frame u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.data     (byte_s1),
		.start    (start_s1),
		.offset   (offset_q),
		.result   (result),
		.position (position)
	);

	thsc_out_stage u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (advance && result.done),
		.result      (result),
		.stall       (out_stall),
		.valid       (out_valid),
		.free        (out_free),
		.status      (status),
		.temperature (temperature)
	);

	// A frame never runs past its CRC byte.
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		position <= POS_CRC)
		else $error("frame position beyond CRC byte");

	// Only a good frame carries a nonzero temperature.
	a_temp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> temperature == '0)
		else $error("temperature set on a failed frame");

	// A good frame's temperature lies within the sensor range.
	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_OK) |->
			(temperature >= -12'sd880) && (temperature <= 12'sd2000))
		else $error("ok result out of range");

	// The input is held back only by a frame-ending byte facing a full output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && result.done && out_valid && out_stall)
		else $error("input stalled without cause");

endmodule

/* verif/thermometer_scratchpad_checker_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the thermometer_scratchpad_checker block.
// It streams scratchpad frames under random sender gaps and receiver stalls.
// It predicts each frame verdict locally. Depends on thsc_pkg and the block's RTL.
module thermometer_scratchpad_checker_test;
	import thsc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 6;

	// Kinds of well-formed frame the traffic generator builds.
	typedef enum int {
		FRAME_GOOD,
		FRAME_BAD_CRC,
		FRAME_ZERO,
		FRAME_ZERO_BAD_CRC
	} frame_kind_t;

	// One expected frame verdict.
	typedef struct {
		status_t            code;
		logic signed [11:0] temp;
	} verdict_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [7:0]         scratch_byte;
	logic               frame_start;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         status;
	logic signed [11:0] temperature;
	logic               cfg_valid;
	logic               cfg_ready;
	logic signed [12:0] cfg_data;

	// Local copy of the frame state and the calibration trim.
	logic [3:0]         pos_m;
	logic [7:0]         crc_m;
	logic               zero_m;
	logic [7:0]         lo_m;
	logic [7:0]         hi_m;
	logic signed [12:0] offset_m;

	verdict_t frame_verdicts[$];
	int       mismatch_count = 0;
	int       cycle_count = 0;
	int       burst_left = 0;
	int       stall_span = 0;
	int       stall_pct = 0;

	thermometer_scratchpad_checker dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.scratch_byte (scratch_byte),
		.frame_start  (frame_start),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.temperature  (temperature),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	// Reflected CRC-8: fold the whole byte in first, then shift out eight bits.
	function automatic logic [7:0] crc8_reflected(input logic [7:0] acc, input logic [7:0] data);
		logic [7:0] r;
		r = acc ^ data;
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	task automatic clear_frame_model();
		pos_m  = '0;
		crc_m  = '0;
		zero_m = 1'b1;
		lo_m   = '0;
		hi_m   = '0;
	endtask

	// Fold one accepted byte into the frame state; queue a verdict on the CRC byte.
	task automatic fold_scratch_byte(input logic [7:0] b, input logic fs);
		verdict_t           v;
		logic signed [15:0] raw;
		logic signed [16:0] sum;
		if (fs || pos_m == POS_LO) begin
			clear_frame_model();
		end
		if (b != 8'd0) begin
			zero_m = 1'b0;
		end
		if (pos_m == POS_CRC) begin
			v.temp = '0;
			if (zero_m) begin
				v.code = ST_ALL_ZERO;
			end else if (crc_m != b) begin
				v.code = ST_CRC_ERR;
			end else begin
				raw = {hi_m, lo_m};
				sum = raw + offset_m;
				if (sum < TEMP_MIN || sum > TEMP_MAX) begin
					v.code = ST_RANGE_ERR;
				end else begin
					v.code = ST_OK;
					v.temp = sum[11:0];
				end
			end
			frame_verdicts.push_back(v);
			clear_frame_model();
		end else begin
			if (pos_m < CRC_LEN) begin
				crc_m = crc8_reflected(crc_m, b);
			end
			if (pos_m == POS_LO) begin
				lo_m = b;
			end else if (pos_m == POS_HI) begin
				hi_m = b;
			end
			pos_m = pos_m + 4'd1;
		end
	endtask

	// Send one byte in bursts with random gaps; entered and left at a falling edge.
	task automatic send_scratch_byte(input logic [7:0] b, input logic fs);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
			gap = $urandom_range(0, 5);
			if (gap > 0) begin
				in_valid     <= 1'b0;
				scratch_byte <= 8'($urandom);
				frame_start  <= 1'($urandom);
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid     <= 1'b1;
		scratch_byte <= b;
		frame_start  <= fs;
		do @(posedge clk); while (in_stall);
		fold_scratch_byte(b, fs);
		@(negedge clk);
	endtask

	// Build a nine-byte frame of the given kind and send it.
	task automatic send_scratchpad(input logic signed [15:0] raw, input logic fs_first,
			input frame_kind_t kind);
		logic [7:0] fb [9];
		logic [7:0] acc;
		fb[0] = raw[7:0];
		fb[1] = raw[15:8];
		for (int i = 2; i < CRC_LEN; i++) begin
			fb[i] = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
		end
		if (kind == FRAME_ZERO || kind == FRAME_ZERO_BAD_CRC) begin
			for (int i = 0; i < CRC_LEN; i++) begin
				fb[i] = 8'd0;
			end
		end
		acc = '0;
		for (int i = 0; i < CRC_LEN; i++) begin
			acc = crc8_reflected(acc, fb[i]);
		end
		case (kind)
			FRAME_BAD_CRC: fb[8] = acc ^ 8'($urandom_range(1, 255));
			FRAME_ZERO_BAD_CRC: fb[8] = 8'($urandom_range(1, 255));
			default: fb[8] = acc;
		endcase
		for (int i = 0; i < FRAME_LEN; i++) begin
			send_scratch_byte(fb[i], (i == 0) ? fs_first : 1'b0);
		end
	endtask

	// Raw readings biased toward the range limits under the current trim.
	function automatic logic signed [15:0] pick_raw();
		int lo_lim;
		int hi_lim;
		lo_lim = int'(TEMP_MIN) - int'(offset_m);
		hi_lim = int'(TEMP_MAX) - int'(offset_m);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 16'(lo_lim + int'($urandom_range(0, hi_lim - lo_lim)));
			4: return 16'(lo_lim);
			5: return 16'(lo_lim - 1);
			6: return 16'(hi_lim);
			7: return 16'(hi_lim + 1);
			8: begin
				case ($urandom_range(0, 3))
					0: return 16'h8000;
					1: return 16'h7FFF;
					2: return 16'h0000;
					default: return 16'hFFFF;
				endcase
			end
			default: return 16'($urandom);
		endcase
	endfunction

	// Hold the sender off until every verdict has arrived and the pipeline is empty.
	task automatic wait_for_idle();
		in_valid <= 1'b0;
		while (frame_verdicts.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_temp_offset(input logic signed [12:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		offset_m = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Reset trim, a frame restarted mid-frame, and a back-to-back all-zero frame.
	task automatic test_reset_offset_and_framing();
		send_scratch_byte(8'hFF, 1'b1);
		send_scratch_byte(8'h00, 1'b0);
		send_scratch_byte(8'h5A, 1'b0);
		send_scratchpad(16'sd2000, 1'b1, FRAME_GOOD);
		send_scratchpad(16'sd0, 1'b0, FRAME_ZERO);
		wait_for_idle();
	endtask

	// One trim setting with random frames, broken sequences and noise.
	task automatic test_offset_phase(input logic signed [12:0] trim, input int n_frames);
		logic        resync;
		int          pick;
		frame_kind_t kind;
		write_temp_offset(trim);
		resync = 1'b1;
		repeat (n_frames) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 8)) begin
					send_scratch_byte(8'($urandom), $urandom_range(0, 3) == 0);
				end
				resync = 1'b1;
			end
			pick = $urandom_range(0, 19);
			case (pick)
				0: kind = FRAME_ZERO;
				1: kind = FRAME_ZERO_BAD_CRC;
				2, 3: kind = FRAME_BAD_CRC;
				default: kind = FRAME_GOOD;
			endcase
			send_scratchpad(pick_raw(), resync ? 1'b1 : 1'($urandom), kind);
			resync = 1'b0;
		end
		wait_for_idle();
	endtask

	// Receiver stall pattern: regimes from no stall to heavy stall.
	always @(negedge clk) begin
		if (stall_span == 0) begin
			stall_span = $urandom_range(16, 96);
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 20;
				2: stall_pct = 50;
				default: stall_pct = 90;
			endcase
		end
		stall_span--;
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Compare each result transfer with the oldest expected verdict.
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (frame_verdicts.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual status %0d temperature %0d",
					$time, status, temperature);
				mismatch_count++;
			end else begin
				want = frame_verdicts.pop_front();
				if (status !== want.code) begin
					$display("%0t: status mismatch, expected %0d, actual %0d",
						$time, want.code, status);
					mismatch_count++;
				end
				if (temperature !== want.temp) begin
					$display("%0t: temperature mismatch, expected %0d, actual %0d",
						$time, want.temp, temperature);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** thermometer_scratchpad_checker: FAILED **");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		scratch_byte = 8'd0;
		frame_start  = 1'b0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		offset_m     = '0;
		clear_frame_model();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		test_reset_offset_and_framing();
		test_offset_phase(13'sd4095, 18);
		test_offset_phase(-13'sd4096, 18);
		test_offset_phase(13'sd0, 18);
		test_offset_phase(13'($urandom_range(0, 8191)), 18);
		test_offset_phase(13'($urandom_range(0, 8191)), 18);

		if (mismatch_count == 0) begin
			$display("** thermometer_scratchpad_checker: PASSED **");
		end else begin
			$display("** thermometer_scratchpad_checker: FAILED **");
		end
		$finish;
	end

endmodule
